/* hw/rtl/celr_pkg.sv */
// Shared types and constants for the coalescing event log ring.
// Holds the entry layout, command and status codes and the sequencer states.
// No dependencies.
package celr_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int OCC_WIDTH     = 13;
   localparam int ENTRY_WIDTH   = 88;

   localparam logic [7:0]  MARKER_TYPE_RESET = 8'hFF;
   localparam logic [15:0] REPEAT_MAX        = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_READ = 2'd1,
      CMD_DROP = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_DROP  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_MARK
   } state_type;

   typedef struct packed {
      logic [31:0]        stamp;
      logic signed [31:0] value;
      logic [7:0]         code;
      logic [15:0]        repeats;
   } entry_type;

   typedef struct packed {
      logic      enable;
      entry_type data;
   } store_wr_type;

endpackage

/* hw/rtl/coalescing_event_log_ring.sv */
// Top level of the coalescing event log ring: command sequencer and pointers.
// Depends on celr_pkg and celr_store.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+----------------------------
//   command | req_cmd, req_event_*, req_read_*,  | start & !busy
//           | req_drop_quantity                  |
//   result  | rsp_status, rsp_read_*, rsp_occ.   | rsp_valid, one cycle
//   config  | csr_wdata                          | csr_valid & csr_ready
//
// A command first reads the entry store, then evaluates and writes back. An
// add that fills the log to depth minus one then writes the marker entry in a
// further state (S_MARK) through the single store write port.
// The result beat appears the cycle after the last write; a new command may be
// accepted in that same cycle. Reset clears pointers and count; the store
// itself holds no reset value. The receiver cannot stall results.
module coalescing_event_log_ring #(
   parameter int LOG_DEPTH = celr_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_event_type,
   input  logic signed [31:0] req_event_value,
   input  logic [31:0]        req_event_time,
   input  logic [15:0]        req_read_offset,
   input  logic [15:0]        req_drop_quantity,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_read_time,
   output logic [15:0]        rsp_read_repeats,
   output logic [7:0]         rsp_read_type,
   output logic signed [31:0] rsp_read_value,
   output logic [celr_pkg::OCC_WIDTH-1:0] rsp_occupancy,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_wdata
);

   localparam int AW = $clog2(LOG_DEPTH);
   localparam int TW = $clog2(LOG_DEPTH + 1);
   localparam int OW = celr_pkg::OCC_WIDTH;

   celr_pkg::state_type state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [TW-1:0] total_ff, total_in;
   logic [7:0]    marker_ff;

   celr_pkg::cmd_type  cmd_ff;
   logic [7:0]         type_ff;
   logic signed [31:0] value_ff;
   logic [31:0]        time_ff;
   logic [15:0]        offset_ff;
   logic [15:0]        qty_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [31:0]        rtime_ff, rtime_in;
   logic [15:0]        rrep_ff, rrep_in;
   logic [7:0]         rtype_ff, rtype_in;
   logic signed [31:0] rvalue_ff, rvalue_in;
   logic [OW-1:0]      occ_ff, occ_in;

   celr_pkg::store_wr_type wr;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   celr_pkg::entry_type    rd_data;

   logic [AW-1:0] last_pos;
   logic [AW-1:0] wp_next;
   logic [AW:0]   read_sum;
   logic [AW-1:0] read_pos;
   logic [AW:0]   drop_sum;
   logic [AW-1:0] drop_pos;
   logic [15:0]   rep_bump;
   logic          coalesce;

   celr_store #(
      .DEPTH (LOG_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != celr_pkg::S_IDLE);
   assign csr_ready = (state_ff == celr_pkg::S_IDLE);

   assign last_pos = (wp_ff == '0) ? AW'(LOG_DEPTH - 1) : wp_ff - AW'(1);
   assign wp_next  = (wp_ff == AW'(LOG_DEPTH - 1)) ? '0 : wp_ff + AW'(1);

   assign read_sum = {1'b0, rp_ff} + req_read_offset[AW:0];
   assign read_pos = (read_sum >= (AW+1)'(LOG_DEPTH)) ?
                     AW'(read_sum - (AW+1)'(LOG_DEPTH)) : read_sum[AW-1:0];

   assign drop_sum = {1'b0, rp_ff} + qty_ff[AW:0];
   assign drop_pos = (drop_sum >= (AW+1)'(LOG_DEPTH)) ?
                     AW'(drop_sum - (AW+1)'(LOG_DEPTH)) : drop_sum[AW-1:0];

   assign rep_bump = (rd_data.repeats != celr_pkg::REPEAT_MAX) ?
                     rd_data.repeats + 16'd1 : rd_data.repeats;

   assign coalesce = (total_ff != '0) && (rd_data.code == type_ff) &&
                     (rd_data.value == value_ff) && (rd_data.stamp == time_ff);

   assign rd_addr = (req_cmd == celr_pkg::CMD_READ) ? read_pos : last_pos;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      rtime_in     = rtime_ff;
      rrep_in      = rrep_ff;
      rtype_in     = rtype_ff;
      rvalue_in    = rvalue_ff;
      occ_in       = occ_ff;
      wr.enable    = 1'b0;
      wr.data      = rd_data;
      wr_addr      = wp_ff;

      unique case (state_ff)
         celr_pkg::S_IDLE: begin
            if (start) begin
               state_in = celr_pkg::S_EVAL;
            end
         end
         celr_pkg::S_EVAL: begin
            state_in     = celr_pkg::S_IDLE;
            rsp_valid_in = 1'b1;
            status_in    = celr_pkg::ST_OK;
            rtime_in     = '0;
            rrep_in      = '0;
            rtype_in     = '0;
            rvalue_in    = '0;
            case (cmd_ff)
               celr_pkg::CMD_ADD: begin
                  if (total_ff == TW'(LOG_DEPTH)) begin
                     status_in = celr_pkg::ST_FULL;
                     if (rd_data.code == marker_ff) begin
                        wr.enable       = 1'b1;
                        wr_addr         = last_pos;
                        wr.data.repeats = rep_bump;
                     end
                  end else if (coalesce) begin
                     wr.enable       = 1'b1;
                     wr_addr         = last_pos;
                     wr.data.repeats = rep_bump;
                  end else begin
                     wr.enable       = 1'b1;
                     wr_addr         = wp_ff;
                     wr.data.stamp   = time_ff;
                     wr.data.value   = value_ff;
                     wr.data.code    = type_ff;
                     wr.data.repeats = 16'd1;
                     wp_in           = wp_next;
                     total_in        = total_ff + TW'(1);
                     if (total_ff == TW'(LOG_DEPTH - 2)) begin
                        state_in     = celr_pkg::S_MARK;
                        rsp_valid_in = 1'b0;
                     end
                  end
               end
               celr_pkg::CMD_READ: begin
                  if (offset_ff >= 16'(total_ff)) begin
                     status_in = celr_pkg::ST_RANGE;
                  end else begin
                     rtime_in  = rd_data.stamp;
                     rrep_in   = rd_data.repeats;
                     rtype_in  = rd_data.code;
                     rvalue_in = rd_data.value;
                  end
               end
               celr_pkg::CMD_DROP: begin
                  if (qty_ff > 16'(total_ff)) begin
                     status_in = celr_pkg::ST_DROP;
                  end else begin
                     rp_in    = drop_pos;
                     total_in = total_ff - TW'(qty_ff);
                  end
               end
               default: begin
               end
            endcase
            occ_in = OW'(total_in);
         end
         celr_pkg::S_MARK: begin
            state_in        = celr_pkg::S_IDLE;
            rsp_valid_in    = 1'b1;
            wr.enable       = 1'b1;
            wr_addr         = wp_ff;
            wr.data.stamp   = time_ff;
            wr.data.value   = $signed(32'(LOG_DEPTH - 1));
            wr.data.code    = marker_ff;
            wr.data.repeats = 16'd1;
            wp_in           = wp_next;
            total_in        = total_ff + TW'(1);
            occ_in          = OW'(total_in);
         end
         default: begin
            state_in = celr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= celr_pkg::S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         total_ff     <= '0;
         marker_ff    <= celr_pkg::MARKER_TYPE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            marker_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff    <= celr_pkg::cmd_type'(req_cmd);
         type_ff   <= req_event_type;
         value_ff  <= req_event_value;
         time_ff   <= req_event_time;
         offset_ff <= req_read_offset;
         qty_ff    <= req_drop_quantity;
      end
      status_ff <= status_in;
      rtime_ff  <= rtime_in;
      rrep_ff   <= rrep_in;
      rtype_ff  <= rtype_in;
      rvalue_ff <= rvalue_in;
      occ_ff    <= occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_read_time    = rtime_ff;
   assign rsp_read_repeats = rrep_ff;
   assign rsp_read_type    = rtype_ff;
   assign rsp_read_value   = rvalue_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

/* hw/rtl/celr_store.sv */
// Entry store of the event log ring: one write port, one registered read port.
// Uses celr_pkg for the entry layout.
module celr_store #(
   parameter int DEPTH = celr_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  celr_pkg::store_wr_type wr,
   input  logic [AW-1:0]          wr_addr,
   input  logic [AW-1:0]          rd_addr,
   output celr_pkg::entry_type    rd_data
);

   celr_pkg::entry_type mem [DEPTH];
   celr_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.enable) begin
         mem[wr_addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/tb_coalescing_event_log_ring.sv */
`timescale 1ns / 100ps
// Self-checking testbench for coalescing_event_log_ring: directed and random command beats,
// each result beat checked against a behavioural copy of the log ring kept in the bench.
// Depends on celr_pkg and the coalescing_event_log_ring RTL.
module tb_coalescing_event_log_ring;

   localparam int RING_DEPTH  = celr_pkg::DEPTH_DEFAULT;
   localparam int IDX_W       = $clog2(RING_DEPTH);
   localparam int STALL_LIMIT = 500;

   typedef struct {
      celr_pkg::status_type           status;
      logic [31:0]                    stamp;
      logic [15:0]                    repeats;
      logic [7:0]                     code;
      logic signed [31:0]             value;
      logic [celr_pkg::OCC_WIDTH-1:0] occupancy;
   } log_outcome_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [1:0]                     req_cmd = celr_pkg::CMD_NONE;
   logic [7:0]                     req_event_type = '0;
   logic signed [31:0]             req_event_value = '0;
   logic [31:0]                    req_event_time = '0;
   logic [15:0]                    req_read_offset = '0;
   logic [15:0]                    req_drop_quantity = '0;
   logic                           rsp_valid;
   logic [1:0]                     rsp_status;
   logic [31:0]                    rsp_read_time;
   logic [15:0]                    rsp_read_repeats;
   logic [7:0]                     rsp_read_type;
   logic signed [31:0]             rsp_read_value;
   logic [celr_pkg::OCC_WIDTH-1:0] rsp_occupancy;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [7:0]                     csr_wdata = '0;

   // behavioural copy of the ring
   celr_pkg::entry_type ring_mem [RING_DEPTH];
   logic [IDX_W-1:0]    head_idx = '0;
   logic [IDX_W-1:0]    tail_idx = '0;
   int                  held = 0;
   logic [7:0]          marker_code = celr_pkg::MARKER_TYPE_RESET;

   log_outcome_type awaited_outcomes [$];
   int              error_count = 0;
   int              idle_cycles = 0;
   bit              pacing_on = 1'b1;
   int              burst_left = 0;

   coalescing_event_log_ring #(
      .LOG_DEPTH(RING_DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_event_type    (req_event_type),
      .req_event_value   (req_event_value),
      .req_event_time    (req_event_time),
      .req_read_offset   (req_read_offset),
      .req_drop_quantity (req_drop_quantity),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_read_time     (rsp_read_time),
      .rsp_read_repeats  (rsp_read_repeats),
      .rsp_read_type     (rsp_read_type),
      .rsp_read_value    (rsp_read_value),
      .rsp_occupancy     (rsp_occupancy),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void bump_repeats(input logic [IDX_W-1:0] pos);
      if (ring_mem[pos].repeats != celr_pkg::REPEAT_MAX) ring_mem[pos].repeats++;
   endfunction

   function automatic void store_entry(input logic [31:0] stamp, input logic signed [31:0] val,
                                       input logic [7:0] code);
      ring_mem[tail_idx].stamp   = stamp;
      ring_mem[tail_idx].value   = val;
      ring_mem[tail_idx].code    = code;
      ring_mem[tail_idx].repeats = 16'd1;
      tail_idx++;
      held++;
   endfunction

   function automatic log_outcome_type apply_log_command(
      input celr_pkg::cmd_type op, input logic [7:0] ty, input logic signed [31:0] val,
      input logic [31:0] stamp, input logic [15:0] off, input logic [15:0] qty);
      log_outcome_type  res;
      logic [IDX_W-1:0] last;
      logic [IDX_W-1:0] pos;
      res.status  = celr_pkg::ST_OK;
      res.stamp   = '0;
      res.repeats = '0;
      res.code    = '0;
      res.value   = '0;
      last = tail_idx - 1'b1;
      case (op)
         celr_pkg::CMD_ADD: begin
            if (held >= RING_DEPTH) begin
               if (ring_mem[last].code == marker_code) bump_repeats(last);
               res.status = celr_pkg::ST_FULL;
            end else if (held != 0 && ring_mem[last].code == ty &&
                         ring_mem[last].value == val && ring_mem[last].stamp == stamp) begin
               bump_repeats(last);
            end else begin
               store_entry(stamp, val, ty);
               if (held == RING_DEPTH - 1) store_entry(stamp, RING_DEPTH - 1, marker_code);
            end
         end
         celr_pkg::CMD_READ: begin
            if (off >= held) begin
               res.status = celr_pkg::ST_RANGE;
            end else begin
               pos = head_idx + off[IDX_W-1:0];
               res.stamp   = ring_mem[pos].stamp;
               res.repeats = ring_mem[pos].repeats;
               res.code    = ring_mem[pos].code;
               res.value   = ring_mem[pos].value;
            end
         end
         celr_pkg::CMD_DROP: begin
            if (qty > held) begin
               res.status = celr_pkg::ST_DROP;
            end else begin
               head_idx = head_idx + qty[IDX_W-1:0];
               held     = held - qty;
            end
         end
         default: ;
      endcase
      res.occupancy = held[celr_pkg::OCC_WIDTH-1:0];
      return res;
   endfunction

   task automatic send_beat(input celr_pkg::cmd_type op, input logic [7:0] ty,
                            input logic signed [31:0] val, input logic [31:0] stamp,
                            input logic [15:0] off, input logic [15:0] qty);
      int gap;
      if (pacing_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
      start             <= 1'b1;
      req_cmd           <= op;
      req_event_type    <= ty;
      req_event_value   <= val;
      req_event_time    <= stamp;
      req_read_offset   <= off;
      req_drop_quantity <= qty;
      do @(posedge clock); while (busy);
      awaited_outcomes.push_back(apply_log_command(op, ty, val, stamp, off, qty));
   endtask

   task automatic add_event(input logic [7:0] ty, input logic signed [31:0] val,
                            input logic [31:0] stamp);
      send_beat(celr_pkg::CMD_ADD, ty, val, stamp, 16'($urandom), 16'($urandom));
   endtask

   task automatic read_entry(input logic [15:0] off);
      send_beat(celr_pkg::CMD_READ, 8'($urandom), $urandom, $urandom, off, 16'($urandom));
   endtask

   task automatic drop_entries(input logic [15:0] qty);
      send_beat(celr_pkg::CMD_DROP, 8'($urandom), $urandom, $urandom, 16'($urandom), qty);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (awaited_outcomes.size() != 0);
   endtask

   task automatic write_marker_type(input logic [7:0] code);
      hold_until_drained();
      csr_valid <= 1'b1;
      csr_wdata <= code;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      marker_code = code;
   endtask

   task automatic test_empty_log();
      read_entry(16'd0);
      read_entry(16'hFFFF);
      drop_entries(16'd0);
      drop_entries(16'd1);
      drop_entries(16'hFFFF);
      send_beat(celr_pkg::CMD_NONE, 8'($urandom), $urandom, $urandom, 16'($urandom),
                16'($urandom));
   endtask

   task automatic test_extremes_and_coalescing();
      add_event(8'h00, 32'sh8000_0000, 32'h0000_0000);
      add_event(8'hFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      add_event(8'hFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      add_event(8'hFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFE);
      add_event(8'hFF, -32'sd1, 32'hFFFF_FFFE);
      read_entry(16'd0);
      read_entry(16'd1);
      read_entry(16'd2);
      read_entry(16'd3);
      read_entry(16'd4);
      read_entry(16'hFFFF);
      drop_entries(16'd0);
      drop_entries(16'd1);
      read_entry(16'd0);
   endtask

   task automatic test_full_log();
      celr_pkg::entry_type newest;
      int                  seq;
      drop_entries(held[15:0]);
      seq = 0;
      while (held < RING_DEPTH) begin
         add_event(seq[7:0], seq, 32'h1000 + seq);
         seq++;
      end
      // full: marker newest, bump it
      add_event(8'h12, 32'sd5, 32'd7);
      read_entry(16'(RING_DEPTH - 1));
      read_entry(16'(RING_DEPTH));
      // full, newest no longer a marker type: leave it alone
      write_marker_type(8'h00);
      add_event(8'h12, 32'sd5, 32'd7);
      read_entry(16'(RING_DEPTH - 1));
      write_marker_type(celr_pkg::MARKER_TYPE_RESET);
      // coalesce into the marker once room is made
      drop_entries(16'd1);
      newest = ring_mem[tail_idx - 1'b1];
      add_event(newest.code, newest.value, newest.stamp);
      read_entry(16'(RING_DEPTH - 2));
      add_event(8'h34, 32'sd9, 32'd11);
      read_entry(16'(RING_DEPTH - 1));
   endtask

   task automatic test_repeat_count();
      celr_pkg::entry_type newest;
      drop_entries(16'd1);
      newest = ring_mem[tail_idx - 1'b1];
      pacing_on = 1'b0;
      repeat (20) add_event(newest.code, newest.value, newest.stamp);
      pacing_on = 1'b1;
      read_entry(16'(held - 1));
   endtask

   task automatic test_random_traffic(input int beats);
      celr_pkg::entry_type newest;
      bit                  filling;
      int                  pick;
      logic [7:0]          ty;
      logic signed [31:0]  val;
      logic [31:0]         stamp;
      filling = 1'b1;
      for (int i = 0; i < beats; i++) begin
         if (i % 48 == 0) filling = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 63) == 0) hold_until_drained();
         pick = $urandom_range(0, 99);
         if (pick < (filling ? 70 : 30)) begin
            if (held != 0 && $urandom_range(0, 2) == 0) begin
               newest = ring_mem[tail_idx - 1'b1];
               add_event(newest.code, newest.value, newest.stamp);
            end else begin
               case ($urandom_range(0, 3))
                  0:       ty = marker_code;
                  1:       ty = 8'($urandom_range(0, 3));
                  default: ty = 8'($urandom);
               endcase
               case ($urandom_range(0, 3))
                  0:       val = $signed($urandom_range(0, 4)) - 2;
                  1:       val = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                  default: val = $urandom;
               endcase
               case ($urandom_range(0, 3))
                  0:       stamp = $urandom_range(0, 3);
                  1:       stamp = 32'hFFFF_FFFF;
                  default: stamp = $urandom;
               endcase
               add_event(ty, val, stamp);
            end
         end else if (pick < (filling ? 85 : 55)) begin
            if ($urandom_range(0, 7) == 0) read_entry(16'($urandom));
            else read_entry(16'($urandom_range(0, held)));
         end else if (pick < 97) begin
            case ($urandom_range(0, 9))
               0:       drop_entries(16'($urandom));
               1:       drop_entries(16'(held + 1));
               2:       drop_entries(16'(held));
               default: drop_entries(16'(filling ? $urandom_range(0, 2) :
                                                    $urandom_range(0, 8)));
            endcase
         end else begin
            send_beat(celr_pkg::CMD_NONE, 8'($urandom), $urandom, $urandom, 16'($urandom),
                      16'($urandom));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      log_outcome_type want;
      if (!reset && rsp_valid) begin
         if (awaited_outcomes.size() == 0) begin
            $error("result beat with no command outstanding");
            error_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("read_time", 64'(want.stamp), 64'(rsp_read_time));
            check_field("read_repeats", 64'(want.repeats), 64'(rsp_read_repeats));
            check_field("read_type", 64'(want.code), 64'(rsp_read_type));
            check_field("read_value", 64'(want.value), 64'(rsp_read_value));
            check_field("occupancy", 64'(want.occupancy), 64'(rsp_occupancy));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_log();
      test_extremes_and_coalescing();
      test_full_log();
      test_repeat_count();
      test_random_traffic(120);
      write_marker_type(8'h00);
      test_random_traffic(120);
      write_marker_type(8'($urandom));
      test_random_traffic(120);
      write_marker_type(8'hFF);
      test_random_traffic(120);
      hold_until_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
